// ----- design/rpr_pkg.sv -----
// rpr_pkg: shared types and constants of the random page replacement block.
// Used by rpr_ctrl, rpr_dp and the top level; depends on nothing.
package rpr_pkg;

    localparam int PAGE_W   = 16;   // page_number / evicted_page port width
    localparam int CNT_W    = 32;   // reference and fault totals
    localparam int FIU_W    = 7;    // frames_in_use register
    localparam int SEED_W   = 16;   // random_seed register and LFSR
    localparam int IDX_O_W  = 6;    // frame_index port width
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED   = 1'b1;

    localparam logic [FIU_W-1:0]  FIU_RESET  = 7'd16;
    localparam logic [SEED_W-1:0] SEED_RESET = 16'h0001;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // latch page, count reference
        logic hit_rec;     // record hit result
        logic fill;        // fill next free frame
        logic div_start;   // advance LFSR, load divider
        logic div_step;    // one restoring-division step
        logic evict;       // replace victim frame
        logic out_load;    // move result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic full;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

// ----- design/rpr_ctrl.sv -----
// rpr_ctrl: sequencing state machine for one page reference.
// Depends on rpr_pkg (t_cmd, t_sts).
module rpr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rpr_pkg::t_sts i_sts,
    output rpr_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_EVICT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOOK;
                end
            end
            S_LOOK: begin
                if (i_sts.hit) begin
                    o_cmd.hit_rec = 1'b1;
                    n_state       = S_DONE;
                end else if (!i_sts.full) begin
                    o_cmd.fill = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/rpr_dp.sv -----
// rpr_dp: frame tags, valid bits, counters, victim LFSR, serial divider and
// output register. Depends on rpr_pkg; driven by rpr_ctrl commands.
module rpr_dp #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rpr_pkg::t_cmd                      i_cmd,
    output rpr_pkg::t_sts                      o_sts,
    input  logic [rpr_pkg::PAGE_W-1:0]         i_page_number,
    input  logic                               i_cfg_we,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rpr_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_hit,
    output logic                               o_evicted_valid,
    output logic [rpr_pkg::PAGE_W-1:0]         o_evicted_page,
    output logic [rpr_pkg::IDX_O_W-1:0]        o_frame_index,
    output logic [rpr_pkg::CNT_W-1:0]          o_reference_total,
    output logic [rpr_pkg::CNT_W-1:0]          o_fault_total
);

    localparam int TAG_W  = (PAGE_BITS < rpr_pkg::PAGE_W) ? PAGE_BITS : rpr_pkg::PAGE_W;
    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int LIM_W  = $clog2(FRAMES + 1);
    localparam int DIV_CW = $clog2(rpr_pkg::SEED_W);
    localparam logic [rpr_pkg::FIU_W-1:0] FRAMES_FIU = rpr_pkg::FIU_W'(FRAMES);
    localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(rpr_pkg::SEED_W - 1);

    // tag store and bookkeeping
    logic [TAG_W-1:0]                r_tags [FRAMES];
    logic [FRAMES-1:0]               r_valid;
    logic [LIM_W-1:0]                r_filled;
    logic [TAG_W-1:0]                r_page;
    logic [rpr_pkg::FIU_W-1:0]       r_fiu;
    logic [rpr_pkg::SEED_W-1:0]      r_lfsr;
    logic [rpr_pkg::CNT_W-1:0]       r_ref_cnt;
    logic [rpr_pkg::CNT_W-1:0]       r_flt_cnt;

    // divider
    logic [rpr_pkg::SEED_W-1:0]      r_dvd;
    logic [LIM_W-1:0]                r_rem;
    logic [DIV_CW-1:0]               r_div_cnt;

    // staged result and output register
    logic                            r_res_hit;
    logic                            r_res_ev;
    logic [TAG_W-1:0]                r_res_page;
    logic [IDX_W-1:0]                r_res_idx;
    logic                            r_out_valid;
    logic                            r_o_hit;
    logic                            r_o_ev;
    logic [TAG_W-1:0]                r_o_page;
    logic [IDX_W-1:0]                r_o_idx;
    logic [rpr_pkg::CNT_W-1:0]       r_o_ref;
    logic [rpr_pkg::CNT_W-1:0]       r_o_flt;

    logic                            match_any;
    logic [IDX_W-1:0]                match_idx;
    logic [rpr_pkg::FIU_W-1:0]       lim_full;
    logic [LIM_W-1:0]                lim;
    logic [rpr_pkg::SEED_W-1:0]      lfsr_next;
    logic [LIM_W:0]                  div_sh;
    logic [LIM_W-1:0]                div_rem_next;
    logic [IDX_W-1:0]                victim;
    logic [IDX_W-1:0]                fill_idx;

    // parallel compare, lowest matching frame wins
    always_comb begin
        match_any = 1'b0;
        match_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_tags[i] == r_page)) begin
                match_any = 1'b1;
                match_idx = IDX_W'(i);
            end
        end
    end

    // frame limit clamped to 1..FRAMES
    always_comb begin
        if (r_fiu == '0) begin
            lim_full = rpr_pkg::FIU_W'(1);
        end else if (r_fiu > FRAMES_FIU) begin
            lim_full = FRAMES_FIU;
        end else begin
            lim_full = r_fiu;
        end
    end
    assign lim = lim_full[LIM_W-1:0];

    // x^16+x^14+x^13+x^11+1, shift right, feedback into bit 15
    assign lfsr_next = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5],
                        r_lfsr[rpr_pkg::SEED_W-1:1]};

    // restoring division step, remainder stays below lim
    assign div_sh       = {r_rem, r_dvd[rpr_pkg::SEED_W-1]};
    assign div_rem_next = (div_sh >= {1'b0, lim}) ? LIM_W'(div_sh - {1'b0, lim})
                                                  : div_sh[LIM_W-1:0];
    assign victim   = r_rem[IDX_W-1:0];
    assign fill_idx = r_filled[IDX_W-1:0];

    assign o_sts.hit      = match_any;
    assign o_sts.full     = (r_filled >= lim);
    assign o_sts.div_last = (r_div_cnt == DIV_LAST);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_filled    <= '0;
            r_fiu       <= rpr_pkg::FIU_RESET;
            r_lfsr      <= rpr_pkg::SEED_RESET;
            r_ref_cnt   <= '0;
            r_flt_cnt   <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rpr_pkg::CFG_FRAMES_IN_USE: r_fiu <= i_cfg_data[rpr_pkg::FIU_W-1:0];
                    rpr_pkg::CFG_RANDOM_SEED: begin
                        r_lfsr <= (i_cfg_data == '0) ? rpr_pkg::SEED_RESET
                                                     : i_cfg_data[rpr_pkg::SEED_W-1:0];
                    end
                    default: ;
                endcase
            end
            if (i_cmd.accept && !(&r_ref_cnt)) begin
                r_ref_cnt <= r_ref_cnt + 1'b1;
            end
            if ((i_cmd.fill || i_cmd.div_start) && !(&r_flt_cnt)) begin
                r_flt_cnt <= r_flt_cnt + 1'b1;
            end
            if (i_cmd.fill) begin
                r_valid[fill_idx] <= 1'b1;
                r_filled          <= r_filled + 1'b1;
            end
            if (i_cmd.div_start) begin
                r_lfsr    <= lfsr_next;
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            if (i_cmd.evict) begin
                r_valid[victim] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_page <= i_page_number[TAG_W-1:0];
        end
        if (i_cmd.hit_rec) begin
            r_res_hit  <= 1'b1;
            r_res_ev   <= 1'b0;
            r_res_page <= '0;
            r_res_idx  <= match_idx;
        end
        if (i_cmd.fill) begin
            r_tags[fill_idx] <= r_page;
            r_res_hit        <= 1'b0;
            r_res_ev         <= 1'b0;
            r_res_page       <= '0;
            r_res_idx        <= fill_idx;
        end
        if (i_cmd.div_start) begin
            r_dvd <= lfsr_next;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[rpr_pkg::SEED_W-2:0], 1'b0};
            r_rem <= div_rem_next;
        end
        if (i_cmd.evict) begin
            r_tags[victim] <= r_page;
            r_res_hit      <= 1'b0;
            r_res_ev       <= 1'b1;
            r_res_page     <= r_tags[victim];
            r_res_idx      <= victim;
        end
        if (i_cmd.out_load) begin
            r_o_hit  <= r_res_hit;
            r_o_ev   <= r_res_ev;
            r_o_page <= r_res_page;
            r_o_idx  <= r_res_idx;
            r_o_ref  <= r_ref_cnt;
            r_o_flt  <= r_flt_cnt;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_hit             = r_o_hit;
    assign o_evicted_valid   = r_o_ev;
    assign o_evicted_page    = rpr_pkg::PAGE_W'(r_o_page);
    assign o_frame_index     = rpr_pkg::IDX_O_W'(r_o_idx);
    assign o_reference_total = r_o_ref;
    assign o_fault_total     = r_o_flt;

endmodule

// ----- design/random_page_replacement.sv -----
// random_page_replacement: top level of the fully associative page frame
// table with random replacement. Instantiates rpr_ctrl and rpr_dp; uses rpr_pkg.
//
// Each input transaction is one page reference; each produces exactly one
// result transaction. The reference is compared against all valid frames in
// parallel. A hit goes from acceptance to result by accept, compare and
// load output; a miss that fills a free frame takes the same steps. A miss
// on a full table also divides and evicts: after the compare, the victim LFSR
// advances, a one-bit-per-cycle restoring divider computes LFSR mod limit,
// then the victim frame is replaced. One reference is in flight at a time; a
// new one is accepted once the previous result sits in the output register,
// even if that result has not yet been taken. The configuration port is
// always ready; write it only while the block is idle. Register 0 is
// frames_in_use (clamped to 1..FRAMES), register 1 is random_seed (a zero
// seed loads as 1, and a write reloads the LFSR). Valid bits clear at reset;
// no clearing pass is needed. Only the low PAGE_BITS bits of a page are kept.
module random_page_replacement #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // reference channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rpr_pkg::PAGE_W-1:0]    i_page_number,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_hit,
    output logic                          o_evicted_valid,
    output logic [rpr_pkg::PAGE_W-1:0]    o_evicted_page,
    output logic [rpr_pkg::IDX_O_W-1:0]   o_frame_index,
    output logic [rpr_pkg::CNT_W-1:0]     o_reference_total,
    output logic [rpr_pkg::CNT_W-1:0]     o_fault_total,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rpr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rpr_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    rpr_pkg::t_cmd cmd;
    rpr_pkg::t_sts sts;

    // writes land directly in the registers, so the port never stalls
    assign o_cfg_ready = 1'b1;

    rpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rpr_dp #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_page_number     (i_page_number),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_hit             (o_hit),
        .o_evicted_valid   (o_evicted_valid),
        .o_evicted_page    (o_evicted_page),
        .o_frame_index     (o_frame_index),
        .o_reference_total (o_reference_total),
        .o_fault_total     (o_fault_total)
    );

endmodule

// ----- design/rpr_checker.sv -----
// rpr_port_checker: port-level assertions for random_page_replacement, and the
// bind that attaches them. Uses rpr_pkg widths.
module rpr_port_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_hit,
    input logic                        o_evicted_valid,
    input logic [rpr_pkg::PAGE_W-1:0]  o_evicted_page,
    input logic [rpr_pkg::IDX_O_W-1:0] o_frame_index,
    input logic [rpr_pkg::CNT_W-1:0]   o_reference_total,
    input logic [rpr_pkg::CNT_W-1:0]   o_fault_total
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_hit) && $stable(o_evicted_valid) &&
             $stable(o_evicted_page) && $stable(o_frame_index) &&
             $stable(o_reference_total) && $stable(o_fault_total)))
        else $error("result changed while stalled");

    // one reference in flight
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second reference accepted while busy");

    // a hit never evicts, and no eviction reports a page
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_hit || !o_evicted_valid)) |->
            (!o_evicted_valid && (o_evicted_page == '0)))
        else $error("eviction fields inconsistent");

    // every fault is also a reference
    a_fault_le_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_fault_total <= o_reference_total))
        else $error("fault total exceeds reference total");

endmodule

bind random_page_replacement rpr_port_checker u_rpr_port_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_hit             (o_hit),
    .o_evicted_valid   (o_evicted_valid),
    .o_evicted_page    (o_evicted_page),
    .o_frame_index     (o_frame_index),
    .o_reference_total (o_reference_total),
    .o_fault_total     (o_fault_total)
);
